FILE: rtl/blzd_pkg.sv
// Shared types and constants for the backward LZSS decompressor.
// Used by the front, queue, back and top-level modules; depends on nothing.
package blzd_pkg;

   // Width of a copy distance: at most 4095 + 3.
   localparam int DIST_W  = 13;
   // Width of a copy count: length minus one, at most 17.
   localparam int COUNT_W = 5;

   localparam logic [3:0]         FLAG_TOKENS = 4'd8;
   localparam logic [COUNT_W-1:0] COUNT_BIAS  = 5'd2;   // length bias 3, less one
   localparam logic [DIST_W-1:0]  DIST_BIAS   = 13'd3;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_final;
   } blzd_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_done;
   } blzd_rsp_type;

   typedef enum logic {
      CMD_LITERAL,
      CMD_COPY
   } blzd_cmd_kind_type;

   typedef struct packed {
      blzd_cmd_kind_type    kind;
      logic [7:0]           lit_byte;
      logic [COUNT_W-1:0]   count_last;
      logic [DIST_W-1:0]    distance;
      logic                 fin;
   } blzd_cmd_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } blzd_fifo_status_type;

endpackage

FILE: rtl/blzd_front.sv
// Token parser: takes compressed bytes and turns them into literal and copy commands.
// Depends on blzd_pkg.
module blzd_front import blzd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  blzd_req_type         req_data,
   input  logic                 queue_full,
   output logic                 req_stall,
   output logic                 cmd_push,
   output blzd_cmd_type         cmd_data
);

   logic [7:0] flags_ff, flags_in;
   logic [3:0] left_ff, left_in;
   logic [7:0] high_ff, high_in;
   logic       pending_ff, pending_in;
   logic       accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      flags_in   = flags_ff;
      left_in    = left_ff;
      high_in    = high_ff;
      pending_in = pending_ff;
      cmd_push   = 1'b0;
      cmd_data.kind       = CMD_LITERAL;
      cmd_data.lit_byte   = req_data.in_byte;
      cmd_data.count_last = {1'b0, high_ff[7:4]} + COUNT_BIAS;
      cmd_data.distance   = {1'b0, high_ff[3:0], req_data.in_byte} + DIST_BIAS;
      cmd_data.fin        = req_data.in_final;

      if (accept) begin
         if (pending_ff) begin
            cmd_push      = 1'b1;
            cmd_data.kind = CMD_COPY;
            pending_in    = 1'b0;
            flags_in      = {flags_ff[6:0], 1'b0};
            left_in       = (left_ff != 4'd0) ? left_ff - 4'd1 : left_ff;
         end else if (left_ff == 4'd0) begin
            flags_in = req_data.in_byte;
            left_in  = FLAG_TOKENS;
         end else if (flags_ff[7]) begin
            high_in    = req_data.in_byte;
            pending_in = 1'b1;
         end else begin
            cmd_push = 1'b1;
            flags_in = {flags_ff[6:0], 1'b0};
            left_in  = left_ff - 4'd1;
         end

         // The last byte of a stream returns the token state to its reset values.
         if (req_data.in_final) begin
            flags_in   = '0;
            left_in    = '0;
            high_in    = '0;
            pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff   <= '0;
         left_ff    <= '0;
         high_ff    <= '0;
         pending_ff <= 1'b0;
      end else begin
         flags_ff   <= flags_in;
         left_ff    <= left_in;
         high_ff    <= high_in;
         pending_ff <= pending_in;
      end
   end

endmodule

FILE: rtl/blzd_fifo.sv
// Short command queue between the token parser and the copy engine.
// Depends on blzd_pkg.
module blzd_fifo import blzd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  blzd_cmd_type         push_data,
   input  logic                 pop,
   output blzd_cmd_type         head,
   output blzd_fifo_status_type status
);

   blzd_cmd_type          entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign head             = entry_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !status.full;
      do_pop    = pop && status.not_empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/blzd_back.sv
// Copy engine: runs literal and copy commands against the history memory and
// drives the response register. Depends on blzd_pkg.
module blzd_back import blzd_pkg::*; #(
   parameter int HISTORY_DEPTH = 8192
) (
   input  logic                 clock,
   input  logic                 reset,
   input  blzd_cmd_type         head,
   input  blzd_fifo_status_type status,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output blzd_rsp_type         rsp_data
);

   localparam int PTR_W = $clog2(HISTORY_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(HISTORY_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(HISTORY_DEPTH);

   logic [7:0]         hist_ff [HISTORY_DEPTH];
   logic [7:0]         mem_q_ff;

   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [PTR_W-1:0]   iss_ptr_ff, iss_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic               st_valid_ff, st_valid_in;
   logic               st_lit_ff;
   logic [7:0]         st_lit_byte_ff;
   logic               st_last_ff;
   logic               st_done_ff;
   logic               out_valid_ff, out_valid_in;
   blzd_rsp_type       out_data_ff;

   logic               out_load, issue, head_is_copy, issue_last, rd_en;
   logic [7:0]         st_byte;
   logic [PTR_W:0]     diff, wrapped;
   logic [PTR_W-1:0]   src;

   always_comb begin
      head_is_copy = (head.kind == CMD_COPY);
      out_load     = st_valid_ff && (!out_valid_ff || !rsp_stall);
      // One byte sits in the stage at most, so every earlier byte of a copy is
      // already in memory or being written on the edge that reads this one.
      issue        = status.not_empty && (!st_valid_ff || out_load);
      issue_last   = !head_is_copy || (cnt_ff == head.count_last);
      pop          = issue && issue_last;
      rd_en        = issue && head_is_copy;

      cnt_in = cnt_ff;
      if (issue) begin
         cnt_in = issue_last ? '0 : cnt_ff + 1'b1;
      end

      iss_ptr_in = iss_ptr_ff;
      if (issue) begin
         iss_ptr_in = (iss_ptr_ff == PTR_LAST) ? '0 : iss_ptr_ff + 1'b1;
      end
      wr_ptr_in = wr_ptr_ff;
      if (out_load) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end

      // Source slot: the issue pointer less the distance, wrapped into the ring.
      diff    = {1'b0, iss_ptr_ff} - {1'b0, PTR_W'(head.distance)};
      wrapped = diff + DEPTH_EXT;
      src     = diff[PTR_W] ? wrapped[PTR_W-1:0] : diff[PTR_W-1:0];

      st_valid_in  = issue || (st_valid_ff && !out_load);
      out_valid_in = out_load || (out_valid_ff && rsp_stall);
      st_byte      = st_lit_ff ? st_lit_byte_ff : mem_q_ff;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         hist_ff[wr_ptr_ff] <= st_byte;
      end
      if (rd_en) begin
         mem_q_ff <= hist_ff[src];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         st_lit_ff      <= !head_is_copy;
         st_lit_byte_ff <= head.lit_byte;
         st_last_ff     <= issue_last;
         st_done_ff     <= issue_last && head.fin;
      end
      if (out_load) begin
         out_data_ff.out_byte    <= st_byte;
         out_data_ff.run_last    <= st_last_ff;
         out_data_ff.stream_done <= st_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         iss_ptr_ff   <= '0;
         wr_ptr_ff    <= '0;
         st_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         iss_ptr_ff   <= iss_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         st_valid_ff  <= st_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   a_ptr_idle: assert property (@(posedge clock) disable iff (reset)
      !st_valid_ff |-> (iss_ptr_ff == wr_ptr_ff))
      else $error("issue and write pointers differ with the stage empty");

   a_cnt_empty: assert property (@(posedge clock) disable iff (reset)
      !status.not_empty |-> (cnt_ff == '0))
      else $error("copy counter not cleared with the queue empty");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (status.not_empty && head.kind == CMD_COPY) |-> (cnt_ff <= head.count_last))
      else $error("copy counter ran past the copy length");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.stream_done) |-> out_data_ff.run_last)
      else $error("end of stream marked on a byte that does not end a run");
`endif

endmodule

FILE: rtl/backward_lzss_decompressor_core.sv
// Backward LZSS decompressor, top level.
// Depends on blzd_pkg, blzd_front, blzd_fifo and blzd_back.
//
// Compressed bytes enter on the req_ channel, highest address first, with
// in_final set on the lowest byte of a stream. Decompressed bytes leave on the
// rsp_ channel in descending address order; run_last marks the last byte that
// one request produced and stream_done the last byte of the stream.
// A request is taken on a clock edge where valid is high and stall is low.
// The parser takes one request per cycle while the four-entry command queue
// has room. Flag bytes and reference high bytes produce no output.
// The copy engine emits one byte per cycle while the queue holds commands and
// rsp_stall is low, bound by the single read port of the history memory: a
// reference of length n (3 to 18) yields n bytes, one read each. A literal taken
// with the queue empty passes the queue, read stage and response register to rsp_valid.
// While rsp_stall is high the response register holds, one more byte waits in
// the read stage, and the queue then fills and raises req_stall.
// Reset clears the token state, the queue and the history pointers; the
// history memory itself is not cleared and needs no clearing pass.
module backward_lzss_decompressor_core import blzd_pkg::*; #(
   parameter int HISTORY_DEPTH = 8192
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  blzd_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output blzd_rsp_type rsp_data
);

   blzd_cmd_type         push_cmd;
   blzd_cmd_type         head_cmd;
   blzd_fifo_status_type queue_status;
   logic                 cmd_push;
   logic                 cmd_pop;

   blzd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_status.full),
      .req_stall  (req_stall),
      .cmd_push   (cmd_push),
      .cmd_data   (push_cmd)
   );

   blzd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_cmd),
      .pop       (cmd_pop),
      .head      (head_cmd),
      .status    (queue_status)
   );

   blzd_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head_cmd),
      .status    (queue_status),
      .pop       (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/tb_backward_lzss_decompressor_core.sv
`timescale 1ns / 100ps
// Testbench for backward_lzss_decompressor_core: random and directed compressed streams
// are checked byte for byte against a behavioral decoder. Needs only blzd_pkg and the
// core RTL.
module tb_backward_lzss_decompressor_core;
   import blzd_pkg::*;

   localparam int HIST_DEPTH   = 8192;
   localparam int LEN_BIAS     = 3;
   localparam int DIST_OFFSET  = 3;
   localparam int MAX_BACK     = 4095 + DIST_OFFSET;
   localparam int RANDOM_REQS  = 140;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int SETTLE_WAIT  = 24;
   localparam int MAX_PRINTS   = 40;

   typedef enum int {
      END_ON_TOKEN,
      END_ON_FLAG,
      END_ON_HIGH
   } stream_end_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   blzd_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   blzd_rsp_type rsp_data;

   // Decoder state, updated as each request is taken.
   logic [7:0]   grp_flags = '0;
   logic [3:0]   grp_left = '0;
   logic [7:0]   copy_high = '0;
   logic         copy_pending = 1'b0;
   logic [7:0]   hist_mem [HIST_DEPTH];
   int           hist_ptr = 0;

   blzd_req_type pending_reqs [$];
   blzd_rsp_type expected_bytes [$];

   int           gen_fill = 0;
   int           total_reqs = 0;
   int           reqs_taken = 0;
   int           bytes_seen = 0;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           calm_left [2] = '{0, 0};
   int           req_gap = 0;
   int           rsp_hold = 0;
   logic         req_taken = 1'b0;

   backward_lzss_decompressor_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTS) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
      mismatch_count++;
   endtask

   // Side 0 is the request sender, side 1 the result receiver. Now and then a side
   // runs a stretch of items with no waiting at all.
   function automatic int draw_wait(input int side);
      if (calm_left[side] > 0) begin
         calm_left[side] = calm_left[side] - 1;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm_left[side] = $urandom_range(10, 40);
      end
      return $urandom_range(0, 8);
   endfunction

   task automatic append_byte(input logic [7:0] b, input logic last, input logic done);
      blzd_rsp_type e;
      hist_mem[hist_ptr] = b;
      hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
      e.out_byte    = b;
      e.run_last    = last;
      e.stream_done = done;
      expected_bytes.push_back(e);
   endtask

   task automatic next_token();
      grp_flags = grp_flags << 1;
      if (grp_left != 0) begin
         grp_left = grp_left - 4'd1;
      end
   endtask

   task automatic predict_request(input blzd_req_type r);
      int run_len;
      int back;
      int k;
      if (copy_pending) begin
         run_len = copy_high[7:4] + LEN_BIAS;
         back    = {copy_high[3:0], r.in_byte} + DIST_OFFSET;
         // One byte at a time, so a copy that overlaps its own output repeats it.
         for (k = 0; k < run_len; k++) begin
            append_byte(hist_mem[(hist_ptr + HIST_DEPTH - back) % HIST_DEPTH],
                        k + 1 == run_len, (k + 1 == run_len) && r.in_final);
         end
         copy_pending = 1'b0;
         next_token();
      end else if (grp_left == 0) begin
         grp_flags = r.in_byte;
         grp_left  = FLAG_TOKENS;
      end else if (grp_flags[7]) begin
         copy_high    = r.in_byte;
         copy_pending = 1'b1;
      end else begin
         append_byte(r.in_byte, 1'b1, r.in_final);
         next_token();
      end
      if (r.in_final) begin
         grp_flags    = '0;
         grp_left     = '0;
         copy_high    = '0;
         copy_pending = 1'b0;
      end
   endtask

   task automatic push_req(input logic [7:0] b, input logic fin);
      blzd_req_type r;
      r.in_byte  = b;
      r.in_final = fin;
      pending_reqs.push_back(r);
   endtask

   // Builds one stream of whole flag groups; the last group may be cut short at a random
   // token. References only reach back into bytes already written since reset.
   task automatic add_stream(input int groups, input stream_end_type ending,
                             input int copy_pct);
      logic [7:0]  flags;
      logic [7:0]  hi [8];
      logic [7:0]  lo [8];
      logic        is_copy [8];
      logic [11:0] enc;
      logic        last_tok;
      logic        drop_low;
      int          g;
      int          t;
      int          cut;
      int          span;
      int          back;
      int          run_code;
      for (g = 0; g < groups; g++) begin
         if (g == groups - 1 && ending == END_ON_FLAG) begin
            push_req(8'($urandom_range(0, 255)), 1'b1);
            return;
         end
         cut   = (g == groups - 1) ? $urandom_range(1, 8) : 8;
         flags = 8'($urandom_range(0, 255));
         for (t = 0; t < cut; t++) begin
            drop_low   = (ending == END_ON_HIGH) && (g == groups - 1) && (t == cut - 1);
            is_copy[t] = (gen_fill >= DIST_OFFSET) &&
                         ($urandom_range(1, 100) <= copy_pct || drop_low);
            flags[7 - t] = is_copy[t];
            if (is_copy[t]) begin
               span = (gen_fill < MAX_BACK) ? gen_fill : MAX_BACK;
               case ($urandom_range(0, 3))
                  0: back = span;
                  1: back = $urandom_range(DIST_OFFSET, (span < 6) ? span : 6);
                  default: back = $urandom_range(DIST_OFFSET, span);
               endcase
               enc      = 12'(back - DIST_OFFSET);
               run_code = $urandom_range(0, 15);
               hi[t]    = {run_code[3:0], enc[11:8]};
               lo[t]    = enc[7:0];
               if (!drop_low) begin
                  gen_fill += run_code + LEN_BIAS;
               end
            end else begin
               lo[t] = 8'($urandom_range(0, 255));
               gen_fill++;
            end
         end
         push_req(flags, 1'b0);
         for (t = 0; t < cut; t++) begin
            last_tok = (g == groups - 1) && (t == cut - 1);
            if (is_copy[t] && last_tok && ending == END_ON_HIGH) begin
               push_req(hi[t], 1'b1);
            end else if (is_copy[t]) begin
               push_req(hi[t], 1'b0);
               push_req(lo[t], last_tok);
            end else begin
               push_req(lo[t], last_tok);
            end
         end
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (pending_reqs.size() != 0) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_gap   <= draw_wait(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : monitor
      blzd_rsp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("byte %0d: unexpected out_byte %h",
                                      bytes_seen, rsp_data.out_byte));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               report_mismatch($sformatf("byte %0d: out_byte %h, expected %h",
                                         bytes_seen, rsp_data.out_byte, want.out_byte));
            end
            if (rsp_data.run_last !== want.run_last) begin
               report_mismatch($sformatf("byte %0d: run_last %b, expected %b",
                                         bytes_seen, rsp_data.run_last, want.run_last));
            end
            if (rsp_data.stream_done !== want.stream_done) begin
               report_mismatch($sformatf("byte %0d: stream_done %b, expected %b",
                                         bytes_seen, rsp_data.stream_done,
                                         want.stream_done));
            end
         end
         bytes_seen++;
         rsp_hold <= draw_wait(1);
      end
      // A request's bytes come out cycles later, so predicting after the check is safe.
      if (!reset && req_valid && !req_stall) begin
         predict_request(req_data);
         reqs_taken++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin : stimulus
      int directed_count;
      int drain;
      int pick;

      // Eight literals at the byte extremes fill one whole group; the next byte is
      // then read as a new flag byte.
      push_req(8'h00, 1'b0);
      push_req(8'h00, 1'b0);
      push_req(8'hFF, 1'b0);
      push_req(8'h55, 1'b0);
      push_req(8'hAA, 1'b0);
      push_req(8'h01, 1'b0);
      push_req(8'h80, 1'b0);
      push_req(8'h7F, 1'b0);
      push_req(8'hFE, 1'b0);
      // Shortest copy at the shortest distance; then a longest copy that overlaps itself,
      // and the stream ends on a literal in the middle of the group.
      push_req(8'hC0, 1'b0);
      push_req(8'h00, 1'b0);
      push_req(8'h00, 1'b0);
      push_req(8'hF0, 1'b0);
      push_req(8'h05, 1'b0);
      push_req(8'h42, 1'b1);
      // A stream that ends on its flag byte yields nothing.
      push_req(8'h80, 1'b1);
      // A reference cut off after its high byte is dropped.
      push_req(8'h80, 1'b0);
      push_req(8'h30, 1'b1);
      // A stream that ends on the low byte of a longest copy.
      push_req(8'h80, 1'b0);
      push_req(8'hF0, 1'b0);
      push_req(8'h10, 1'b1);
      gen_fill       = 48;
      directed_count = pending_reqs.size();

      while (pending_reqs.size() < directed_count + RANDOM_REQS) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            add_stream($urandom_range(1, 3), END_ON_FLAG, $urandom_range(20, 80));
         end else if (pick == 1) begin
            add_stream($urandom_range(1, 3), END_ON_HIGH, $urandom_range(20, 80));
         end else begin
            add_stream($urandom_range(1, 3), END_ON_TOKEN, $urandom_range(20, 80));
         end
      end
      total_reqs = pending_reqs.size();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (reqs_taken != total_reqs);
      drain = 0;
      while (expected_bytes.size() != 0 && drain < DRAIN_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      if (expected_bytes.size() != 0) begin
         report_mismatch($sformatf("%0d expected bytes never arrived",
                                   expected_bytes.size()));
      end
      repeat (SETTLE_WAIT) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
